>>> design/dsrq_pkg.sv
// Package for the depth sorted record queue.
// Holds sizes, the record and control types and the operation codes.
// No dependencies.
package dsrq_pkg;

    localparam int MAX_RECORDS = 1024;
    localparam int KEY_BITS    = 32;
    localparam int TAG_BITS    = 16;
    localparam int COUNT_BITS  = $clog2(MAX_RECORDS + 1);

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } record_t;

    typedef struct packed
    {
        logic    load;
        logic    take;
        record_t rec;
    } cell_ctrl_t;

endpackage

>>> design/depth_sorted_record_queue.sv
// Depth sorted record queue: a chain of MAX_RECORDS cells kept in
// descending key order, ties in load order. Requests update the chain in place:
// a load is broadcast to all cells, which each keep, take the new record or
// take their neighbour's in the same cycle; a take shifts the chain one cell
// towards the head. A take returns its result from an output register, and
// the next request is accepted while that result is being taken, so the
// block runs at one request per cycle unless the output side stalls. A load
// into a full queue is dropped and sets the sticky overflow flag; a take on
// an empty queue returns empty_res with zero fields. No clearing pass.
module depth_sorted_record_queue
    import dsrq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [KEY_BITS-1:0] depth_key,
    input  logic [TAG_BITS-1:0] tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KEY_BITS-1:0] out_key,
    output logic [TAG_BITS-1:0] out_tag,
    output logic                last,
    output logic                empty_res,
    output logic                overflow
);

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(MAX_RECORDS);
    localparam logic [COUNT_BITS-1:0] ONE_COUNT  = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [KEY_BITS-1:0]   out_key_reg;
    logic [TAG_BITS-1:0]   out_tag_reg;
    logic                  last_reg;
    logic                  empty_res_reg;
    logic                  overflow_out_reg;

    logic       accept;
    logic       is_take;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;
    record_t    head_rec;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_take  = (op_t'(op) == OP_TAKE);
    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);

    always_comb
    begin
        ctrl.load    = accept && !is_take && !full;
        ctrl.take    = accept && is_take && !empty;
        ctrl.rec.key = depth_key;
        ctrl.rec.tag = tag;

        count_next = count_reg;
        if (ctrl.load)
        begin
            count_next = count_reg + ONE_COUNT;
        end
        else if (ctrl.take)
        begin
            count_next = count_reg - ONE_COUNT;
        end

        overflow_next = overflow_reg || (accept && !is_take && full);

        out_valid_next = out_valid_reg;
        if (accept && is_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    dsrq_chain u_chain
    (
        .clk      (clk),
        .ctrl     (ctrl),
        .count    (count_reg),
        .head_rec (head_rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_take)
        begin
            out_key_reg      <= empty ? '0 : head_rec.key;
            out_tag_reg      <= empty ? '0 : head_rec.tag;
            last_reg         <= (count_reg == ONE_COUNT);
            empty_res_reg    <= empty;
            overflow_out_reg <= overflow_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_tag   = out_tag_reg;
    assign last      = last_reg;
    assign empty_res = empty_res_reg;
    assign overflow  = overflow_out_reg;

endmodule

>>> design/dsrq_cell.sv
// One sorting cell: holds a single record of the queue.
// Depends on dsrq_pkg for the record and control types.
module dsrq_cell
    import dsrq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occ,
    input  record_t    prev_rec,
    input  logic       prev_keep,
    input  record_t    next_rec,
    output record_t    rec,
    output logic       keep
);

    record_t rec_reg;
    record_t rec_next;

    assign keep = occ && (rec_reg.key >= ctrl.rec.key);
    assign rec  = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.load)
        begin
            if (keep)
            begin
                rec_next = rec_reg;
            end
            else if (prev_keep)
            begin
                rec_next = ctrl.rec;
            end
            else
            begin
                rec_next = prev_rec;
            end
        end
        else if (ctrl.take)
        begin
            rec_next = next_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

>>> design/dsrq_chain.sv
// Row of sorting cells, head at cell zero.
// Depends on dsrq_pkg and dsrq_cell.
module dsrq_chain
    import dsrq_pkg::*;
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [COUNT_BITS-1:0] count,
    output record_t               head_rec
);

    record_t rec_arr  [MAX_RECORDS];
    logic    keep_arr [MAX_RECORDS];

    assign head_rec = rec_arr[0];

    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(i);
        record_t prev_rec;
        logic    prev_keep;
        record_t next_rec;
        logic    occ;

        assign occ = IDX < count;

        if (i == 0)
        begin : g_head
            assign prev_rec  = ctrl.rec;
            assign prev_keep = 1'b1;
        end
        else
        begin : g_body
            assign prev_rec  = rec_arr[i-1];
            assign prev_keep = keep_arr[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_tail
            assign next_rec = rec_arr[i];
        end
        else
        begin : g_mid
            assign next_rec = rec_arr[i+1];
        end

        dsrq_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl),
            .occ       (occ),
            .prev_rec  (prev_rec),
            .prev_keep (prev_keep),
            .next_rec  (next_rec),
            .rec       (rec_arr[i]),
            .keep      (keep_arr[i])
        );
    end

endmodule

>>> design/dsrq_checker.sv
// Port checker for the depth sorted record queue, bound to the top level.
// Depends on dsrq_pkg for field widths.
module dsrq_checker
    import dsrq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [KEY_BITS-1:0] out_key,
    input logic [TAG_BITS-1:0] out_tag,
    input logic                last,
    input logic                empty_res,
    input logic                overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
            && $stable(last) && $stable(empty_res) && $stable(overflow))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> out_key == '0 && out_tag == '0 && !last)
        else $error("empty result carries data");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request accepted while result stalled");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("not ready with no result pending");

    a_result_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result raised without an accepted request");

endmodule

bind depth_sorted_record_queue dsrq_checker u_dsrq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .last      (last),
    .empty_res (empty_res),
    .overflow  (overflow)
);

>>> sim/tb_top.sv
// Testbench for depth_sorted_record_queue: directed and random load/take requests
// checked against an in-bench sorted store model, with random idling on both sides.
// Depends on dsrq_pkg and the depth_sorted_record_queue RTL.
`timescale 1ns / 1ps

module tb_top;
    import dsrq_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct
    {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic                last;
        logic                is_empty;
        logic                ovf;
    } take_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    op_t                 op = OP_LOAD;
    logic [KEY_BITS-1:0] depth_key = '0;
    logic [TAG_BITS-1:0] tag = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic                last;
    logic                empty_res;
    logic                overflow;

    record_t      model_records[$];
    logic         model_overflow = 1'b0;
    take_result_t expected_takes[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           stall_cycles = 0;

    depth_sorted_record_queue DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .depth_key (depth_key),
        .tag       (tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_key   (out_key),
        .out_tag   (out_tag),
        .last      (last),
        .empty_res (empty_res),
        .overflow  (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void depth_order_predict(op_t req_op, logic [KEY_BITS-1:0] key,
                                                logic [TAG_BITS-1:0] rec_tag);
        take_result_t res;
        record_t      rec;
        int           pos;
        if (req_op == OP_LOAD)
        begin
            if (model_records.size() >= MAX_RECORDS)
            begin
                model_overflow = 1'b1;
            end
            else
            begin
                pos = 0;
                while (pos < model_records.size() && model_records[pos].key >= key)
                    pos++;
                rec.key = key;
                rec.tag = rec_tag;
                model_records.insert(pos, rec);
            end
        end
        else
        begin
            res = '{default: '0};
            if (model_records.size() == 0)
            begin
                res.is_empty = 1'b1;
            end
            else
            begin
                rec = model_records.pop_front();
                res.key  = rec.key;
                res.tag  = rec.tag;
                res.last = (model_records.size() == 0);
            end
            res.ovf = model_overflow;
            expected_takes.insert(expected_takes.size(), res);
        end
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_depth();
        case ($urandom_range(3))
            0:       return KEY_BITS'($urandom_range(3));
            1:       return KEY_BITS'($urandom);
            2:       return KEY_BITS'($urandom_range(255)) << 16;
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    task automatic send_request(op_t req_op, logic [KEY_BITS-1:0] key,
                                logic [TAG_BITS-1:0] rec_tag);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        op        <= req_op;
        depth_key <= key;
        tag       <= rec_tag;
        do
            @(posedge clk);
        while (!in_ready);
        depth_order_predict(req_op, key, rec_tag);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_takes.size() != 0);
    endtask

    task automatic check_take_result();
        take_result_t exp_res;
        if (expected_takes.size() == 0)
        begin
            $error("unexpected result: out_key %h out_tag %h", out_key, out_tag);
            error_count++;
        end
        else
        begin
            exp_res = expected_takes.pop_front();
            if (out_key !== exp_res.key)
            begin
                $error("out_key: expected %h, got %h", exp_res.key, out_key);
                error_count++;
            end
            if (out_tag !== exp_res.tag)
            begin
                $error("out_tag: expected %h, got %h", exp_res.tag, out_tag);
                error_count++;
            end
            if (last !== exp_res.last)
            begin
                $error("last: expected %b, got %b", exp_res.last, last);
                error_count++;
            end
            if (empty_res !== exp_res.is_empty)
            begin
                $error("empty_res: expected %b, got %b", exp_res.is_empty, empty_res);
                error_count++;
            end
            if (overflow !== exp_res.ovf)
            begin
                $error("overflow: expected %b, got %b", exp_res.ovf, overflow);
                error_count++;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_take_result();
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic test_empty_take();
        send_request(OP_TAKE, '1, '1);
    endtask

    task automatic test_extreme_fields();
        send_request(OP_LOAD, '1, '0);
        send_request(OP_LOAD, '0, '1);
        send_request(OP_LOAD, 32'h0001_0000, 16'h1234);
        send_request(OP_LOAD, 32'h8000_0000, 16'h8000);
        send_request(OP_TAKE, '0, '0);
        send_request(OP_TAKE, '0, '0);
        send_request(OP_TAKE, '0, '0);
        send_request(OP_TAKE, '0, '0);
        send_request(OP_TAKE, '0, '0);
    endtask

    task automatic test_equal_keys();
        send_request(OP_LOAD, 32'd5, 16'h000a);
        send_request(OP_LOAD, 32'd5, 16'h000b);
        send_request(OP_LOAD, 32'd5, 16'h000c);
        send_request(OP_LOAD, 32'd9, 16'h000d);
        send_request(OP_LOAD, 32'd5, 16'h000e);
        repeat (5)
            send_request(OP_TAKE, '0, '0);
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        int sent;
        int burst;
        int load_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < count)
        begin
            burst    = $urandom_range(40, 4);
            load_pct = $urandom_range(1) ? 75 : 30;
            for (int i = 0; i < burst && sent < count; i++)
            begin
                if ($urandom_range(99) < load_pct)
                    send_request(OP_LOAD, pick_depth(), TAG_BITS'($urandom));
                else
                    send_request(OP_TAKE, KEY_BITS'($urandom), TAG_BITS'($urandom));
                sent++;
                if (sent == count / 2)
                    hold_until_drained();
            end
        end
    endtask

    task automatic test_full_store();
        repeat (MAX_RECORDS + 2)
            send_request(OP_LOAD, KEY_BITS'($urandom_range(15)) << 16, TAG_BITS'($urandom));
        repeat (4)
            send_request(OP_TAKE, '0, '0);
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 22;
        recv_idle_pct = 74;
        test_empty_take();
        test_extreme_fields();
        test_equal_keys();
        test_random_traffic(22, 74, 84);
        test_random_traffic(74, 22, 84);
        test_random_traffic(0, 0, 84);
        test_full_store();
        hold_until_drained();
        repeat (20)
            @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
